// ===== rtl/core/neighbor_table_with_eviction_macros.svh =====
// assertion macros shared by the neighbor table rtl
// expects clk and rst_n in the scope of each use
`ifndef NEIGHBOR_TABLE_WITH_EVICTION_MACROS_SVH
`define NEIGHBOR_TABLE_WITH_EVICTION_MACROS_SVH

// condition holds at every edge out of reset
`define NTE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define NTE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/nte_pkg.sv =====
// types, codes and constants of the neighbor table
// no dependencies
`timescale 1ns / 1ps

package nte_pkg;

  localparam int MAX_ENTRIES_DFLT = 16;
  localparam int READ_CAP         = 16;

  localparam int ID_W     = 16;
  localparam int LEVEL_W  = 8;
  localparam int RSSI_W   = 12;
  localparam int LIMIT_W  = 5;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RSSI_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_MODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PARENTS_WANTED = 2'd3;

  // configuration reset values
  localparam logic signed [RSSI_W-1:0] RSSI_THRESHOLD_RST = '0;
  localparam logic [LIMIT_W-1:0]       TABLE_LIMIT_RST    = 5'd16;
  localparam logic                     SIGNAL_MODE_RST    = 1'b0;
  localparam logic [LIMIT_W-1:0]       PARENTS_WANTED_RST = 5'd1;

  typedef enum logic [1:0] {
    MODE_STORE,
    MODE_CLEAR,
    MODE_READ,
    MODE_NONE
  } nte_mode_t;

  typedef enum logic [2:0] {
    ST_INSERTED,
    ST_UPDATED,
    ST_REPLACED,
    ST_REFUSED,
    ST_BELOW_THRESHOLD,
    ST_CLEARED,
    ST_ENTRY,
    ST_EMPTY
  } nte_status_t;

  typedef struct packed {
    nte_mode_t                 mode;
    logic [ID_W-1:0]           neighbor_id;
    logic [ID_W-1:0]           neighbor_sink;
    logic [LEVEL_W-1:0]        neighbor_level;
    logic signed [RSSI_W-1:0]  neighbor_rssi;
  } nte_in_t;

  typedef struct packed {
    nte_status_t               status;
    logic [ID_W-1:0]           entry_id;
    logic [ID_W-1:0]           entry_sink;
    logic [LEVEL_W-1:0]        entry_level;
    logic signed [RSSI_W-1:0]  entry_rssi;
    logic                      last;
  } nte_out_t;

  // one table entry, 52 bits
  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic [ID_W-1:0]           sink;
    logic [LEVEL_W-1:0]        level;
    logic signed [RSSI_W-1:0]  rssi;
  } nte_entry_t;

  // single result that carries only a status
  function automatic nte_out_t nte_status_result(nte_status_t st);
    nte_out_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/core/nte_entry_ram.sv =====
// entry store of the neighbor table: one write port, one registered read port
// depends on nte_pkg
`timescale 1ns / 1ps

module nte_entry_ram #(
  parameter int DEPTH = nte_pkg::MAX_ENTRIES_DFLT,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  nte_pkg::nte_entry_t wr_data,
  input  logic [AW-1:0]       rd_addr,
  output nte_pkg::nte_entry_t rd_data
);

  nte_pkg::nte_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/neighbor_table_with_eviction.sv =====
// neighbor table with eviction: top level, sequencer and result register
// depends on nte_pkg, nte_entry_ram and neighbor_table_with_eviction_macros.svh
`timescale 1ns / 1ps
//
//  channel | ports                              | payload
//  --------+------------------------------------+-----------------------------
//  input   | in_valid  in_ready  in_data        | nte_pkg::nte_in_t
//  result  | out_valid out_ready out_data       | nte_pkg::nte_out_t
//  config  | cfg_wr_en cfg_index cfg_wdata      | 12 bit data, write only
//
//  one transaction at a time; a single compare unit walks the entry ram
//  store: a scan over the valid entries, plus a compaction pass after the victim on replace,
//    bounded by the one-read-per-cycle port of the entry ram
//  clear, unused mode and a store under the threshold finish in the accept cycle
//  read: S_RD_ADDR then S_RD_EMIT per emitted entry, plus any out_ready stall
//  synchronous active-low reset clears control and config; the entry ram is
//    not cleared, entries at or above the count are never read

module neighbor_table_with_eviction #(
  parameter int MAX_ENTRIES = nte_pkg::MAX_ENTRIES_DFLT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  nte_pkg::nte_in_t                      in_data,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output nte_pkg::nte_out_t                     out_data,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [nte_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [nte_pkg::CFG_W-1:0]             cfg_wdata
);

`include "neighbor_table_with_eviction_macros.svh"

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  // common width for count versus limit and read-size compares
  localparam int CMP_W = (CNT_W > nte_pkg::LIMIT_W) ? CNT_W : nte_pkg::LIMIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_EMIT,
    S_RD_ADDR,
    S_RD_EMIT
  } state_t;

  // sequencer state
  state_t                          state_r, state_nxt;
  nte_pkg::nte_in_t                item_r, item_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [CNT_W-1:0]                iss_idx_r, iss_idx_nxt;   // next ram address
  logic                            pipe_vld_r, pipe_vld_nxt; // ram data valid
  logic [IDX_W-1:0]                pipe_idx_r, pipe_idx_nxt; // address of ram data
  logic                            found_r, found_nxt;
  logic [IDX_W-1:0]                match_idx_r, match_idx_nxt;
  logic [IDX_W-1:0]                vic_idx_r, vic_idx_nxt;
  logic [nte_pkg::LEVEL_W-1:0]     vic_level_r, vic_level_nxt;
  logic signed [nte_pkg::RSSI_W-1:0] vic_rssi_r, vic_rssi_nxt;
  nte_pkg::nte_status_t            status_r, status_nxt;
  logic [CNT_W-1:0]                rd_want_r, rd_want_nxt;

  // configuration
  logic signed [nte_pkg::RSSI_W-1:0] thr_r, thr_nxt;
  logic [nte_pkg::LIMIT_W-1:0]     limit_r, limit_nxt;
  logic                            sq_mode_r, sq_mode_nxt;
  logic [nte_pkg::LIMIT_W-1:0]     pw_r, pw_nxt;

  // result register
  logic                            out_valid_r, out_valid_nxt;
  nte_pkg::nte_out_t               out_data_r, out_data_nxt;

  // entry ram
  logic                            mem_we;
  logic [IDX_W-1:0]                mem_waddr;
  nte_pkg::nte_entry_t             mem_wdata;
  nte_pkg::nte_entry_t             mem_rdata;
  nte_pkg::nte_entry_t             new_entry;

  logic                            out_free;
  logic                            in_fire;
  logic                            below_thr;
  logic [nte_pkg::LIMIT_W-1:0]     pw_eff;
  logic [CMP_W-1:0]                want_a;
  logic [CMP_W-1:0]                want_b;
  logic                            has_room;
  logic                            better;
  logic                            refuse;
  logic                            rd_last;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign new_entry = '{id:    item_r.neighbor_id,
                       sink:  item_r.neighbor_sink,
                       level: item_r.neighbor_level,
                       rssi:  item_r.neighbor_rssi};

  // threshold of zero turns the check off
  assign below_thr = (thr_r != '0) &&
                     ($signed(in_data.neighbor_rssi) < $signed(thr_r));

  // read size: min(max(parents_wanted, 1), count, read cap)
  assign pw_eff  = (pw_r == '0) ? nte_pkg::LIMIT_W'(1) : pw_r;
  assign want_a  = (CMP_W'(pw_eff) < CMP_W'(count_r)) ? CMP_W'(pw_eff) : CMP_W'(count_r);
  assign want_b  = (want_a > CMP_W'(nte_pkg::READ_CAP)) ? CMP_W'(nte_pkg::READ_CAP) : want_a;

  // room for an append: below the limit and below the ram depth
  assign has_room = (CMP_W'(count_r) < CMP_W'(limit_r)) &&
                    (count_r != CNT_W'(MAX_ENTRIES));

  // shared compare unit: does the entry from the ram beat the current victim
  always_comb begin
    if (!sq_mode_r) begin
      better = (mem_rdata.level > vic_level_r) ||
               ((mem_rdata.level == vic_level_r) &&
                ($signed(mem_rdata.rssi) < $signed(vic_rssi_r)));
    end else begin
      better = ($signed(mem_rdata.rssi) < $signed(vic_rssi_r)) ||
               (($signed(mem_rdata.rssi) == $signed(vic_rssi_r)) &&
                (mem_rdata.level > vic_level_r));
    end
  end

  // newcomer must be at least as good as the victim
  assign refuse = sq_mode_r ? ($signed(item_r.neighbor_rssi) < $signed(vic_rssi_r))
                            : (item_r.neighbor_level > vic_level_r);

  assign rd_last = (CNT_W'(iss_idx_r + 1'b1) == rd_want_r);

  nte_entry_ram #(
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (iss_idx_r[IDX_W-1:0]),
    .rd_data (mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    count_nxt     = count_r;
    iss_idx_nxt   = iss_idx_r;
    pipe_vld_nxt  = pipe_vld_r;
    pipe_idx_nxt  = pipe_idx_r;
    found_nxt     = found_r;
    match_idx_nxt = match_idx_r;
    vic_idx_nxt   = vic_idx_r;
    vic_level_nxt = vic_level_r;
    vic_rssi_nxt  = vic_rssi_r;
    status_nxt    = status_r;
    rd_want_nxt   = rd_want_r;
    thr_nxt       = thr_r;
    limit_nxt     = limit_r;
    sq_mode_nxt   = sq_mode_r;
    pw_nxt        = pw_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[IDX_W-1:0];
    mem_wdata     = new_entry;

    // configuration writes; the user must write only while idle, the block itself does not enforce it
    if (cfg_wr_en) begin
      case (cfg_index)
        nte_pkg::CFG_RSSI_THRESHOLD: thr_nxt     = $signed(cfg_wdata[nte_pkg::RSSI_W-1:0]);
        nte_pkg::CFG_TABLE_LIMIT:    limit_nxt   = cfg_wdata[nte_pkg::LIMIT_W-1:0];
        nte_pkg::CFG_SIGNAL_MODE:    sq_mode_nxt = cfg_wdata[0];
        nte_pkg::CFG_PARENTS_WANTED: pw_nxt      = cfg_wdata[nte_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          item_nxt = in_data;
          case (in_data.mode)
            nte_pkg::MODE_STORE: begin
              if (below_thr) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = nte_pkg::nte_status_result(nte_pkg::ST_BELOW_THRESHOLD);
              end else begin
                // one pass finds the last id match and the victim together
                iss_idx_nxt  = '0;
                pipe_vld_nxt = 1'b0;
                found_nxt    = 1'b0;
                state_nxt    = S_SCAN;
              end
            end
            nte_pkg::MODE_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_data_nxt  = nte_pkg::nte_status_result(nte_pkg::ST_CLEARED);
            end
            nte_pkg::MODE_READ: begin
              if (want_b == '0) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = nte_pkg::nte_status_result(nte_pkg::ST_EMPTY);
              end else begin
                iss_idx_nxt = '0;
                rd_want_nxt = CNT_W'(want_b);
                state_nxt   = S_RD_ADDR;
              end
            end
            default: ;  // unused mode: no result, no change
          endcase
        end
      end

      S_SCAN: begin
        // issue side
        if (iss_idx_r < count_r) begin
          pipe_vld_nxt = 1'b1;
          pipe_idx_nxt = iss_idx_r[IDX_W-1:0];
          iss_idx_nxt  = iss_idx_r + 1'b1;
        end else begin
          pipe_vld_nxt = 1'b0;
        end
        // compare side
        if (pipe_vld_r) begin
          if (mem_rdata.id == item_r.neighbor_id) begin
            found_nxt     = 1'b1;
            match_idx_nxt = pipe_idx_r;
          end
          // first entry seeds the victim, later ones must beat it
          if ((pipe_idx_r == '0) || better) begin
            vic_idx_nxt   = pipe_idx_r;
            vic_level_nxt = mem_rdata.level;
            vic_rssi_nxt  = mem_rdata.rssi;
          end
        end
        if ((iss_idx_r == count_r) && !pipe_vld_r) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_nxt = S_EMIT;
        if (found_r) begin
          mem_we     = 1'b1;
          mem_waddr  = match_idx_r;
          status_nxt = nte_pkg::ST_UPDATED;
        end else if (has_room) begin
          mem_we     = 1'b1;
          mem_waddr  = count_r[IDX_W-1:0];
          count_nxt  = count_r + 1'b1;
          status_nxt = nte_pkg::ST_INSERTED;
        end else if ((count_r == '0) || refuse) begin
          status_nxt = nte_pkg::ST_REFUSED;
        end else begin
          // compact from the victim on, then append at the tail
          iss_idx_nxt  = CNT_W'(vic_idx_r) + 1'b1;
          pipe_vld_nxt = 1'b0;
          status_nxt   = nte_pkg::ST_REPLACED;
          state_nxt    = S_SHIFT;
        end
      end

      S_SHIFT: begin
        if (iss_idx_r < count_r) begin
          pipe_vld_nxt = 1'b1;
          pipe_idx_nxt = iss_idx_r[IDX_W-1:0];
          iss_idx_nxt  = iss_idx_r + 1'b1;
        end else begin
          pipe_vld_nxt = 1'b0;
        end
        if (pipe_vld_r) begin
          // move entry up one place
          mem_we    = 1'b1;
          mem_waddr = IDX_W'(pipe_idx_r - 1'b1);
          mem_wdata = mem_rdata;
        end else if (iss_idx_r == count_r) begin
          // pipe drained: new entry into the last slot
          mem_we    = 1'b1;
          mem_waddr = IDX_W'(count_r - 1'b1);
          mem_wdata = new_entry;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = nte_pkg::nte_status_result(status_r);
          state_nxt     = S_IDLE;
        end
      end

      S_RD_ADDR: begin
        // address set up, data lands next cycle
        state_nxt = S_RD_EMIT;
      end

      S_RD_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status:      nte_pkg::ST_ENTRY,
                            entry_id:    mem_rdata.id,
                            entry_sink:  mem_rdata.sink,
                            entry_level: mem_rdata.level,
                            entry_rssi:  mem_rdata.rssi,
                            last:        rd_last};
          if (rd_last) begin
            state_nxt = S_IDLE;
          end else begin
            iss_idx_nxt = iss_idx_r + 1'b1;
            state_nxt   = S_RD_ADDR;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      iss_idx_r   <= '0;
      pipe_vld_r  <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= nte_pkg::RSSI_THRESHOLD_RST;
      limit_r     <= nte_pkg::TABLE_LIMIT_RST;
      sq_mode_r   <= nte_pkg::SIGNAL_MODE_RST;
      pw_r        <= nte_pkg::PARENTS_WANTED_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      iss_idx_r   <= iss_idx_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      thr_r       <= thr_nxt;
      limit_r     <= limit_nxt;
      sq_mode_r   <= sq_mode_nxt;
      pw_r        <= pw_nxt;
    end
    item_r      <= item_nxt;
    pipe_idx_r  <= pipe_idx_nxt;
    match_idx_r <= match_idx_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_level_r <= vic_level_nxt;
    vic_rssi_r  <= vic_rssi_nxt;
    status_r    <= status_nxt;
    rd_want_r   <= rd_want_nxt;
    out_data_r  <= out_data_nxt;
  end

  // checks
  `NTE_ASSERT_ALWAYS(a_count_max, count_r <= CNT_W'(MAX_ENTRIES), "entry count above depth")
  `NTE_ASSERT_NEXT(a_idle_quiet, state_r == S_IDLE && !in_fire, !$rose(out_valid_r),
    "result appeared without a transaction")
  `NTE_ASSERT_NEXT(a_count_step, 1'b1,
    count_r == $past(count_r) || count_r == $past(count_r) + 1'b1 || count_r == '0,
    "entry count jumped")
  `NTE_ASSERT_IMPLY(a_match_inside, state_r == S_DECIDE && found_r,
    CNT_W'(match_idx_r) < count_r, "id match outside the valid entries")
  `NTE_ASSERT_IMPLY(a_shift_src, state_r == S_SHIFT && pipe_vld_r, pipe_idx_r != '0,
    "compaction moved the head entry")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the neighbor table with eviction: directed table then random phases
// depends on nte_pkg and the neighbor_table_with_eviction rtl

module tb_top;
  import nte_pkg::*;

  localparam int IDLE_PCT        = 27;
  localparam int DRAIN_GUARD     = 64;     // longest store plus margin
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_TXNS      = 21;
  localparam int PHASE_COUNT     = 6;
  localparam int END_WAIT_LIMIT  = 20000;
  localparam int REPORT_LIMIT    = 10;

  // one row of the directed table: a transaction or a register write
  typedef enum logic {ROW_TXN, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    nte_in_t              txn;
    logic                 pinned;      // status typed into the table
    nte_status_t          pin_status;
  } dir_row_t;

  // clock, reset and block inputs, all known from time zero
  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  nte_in_t         in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  nte_out_t        out_data;
  logic            cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // travels alongside in_data so the monitor knows a typed-in status
  logic            offer_pinned     = 1'b0;
  nte_status_t     offer_pin_status = ST_INSERTED;

  // shadow copy of the table and its registers
  nte_entry_t                nbr_table [MAX_ENTRIES_DFLT];
  int                        nbr_count  = 0;
  logic signed [RSSI_W-1:0]  rssi_floor = RSSI_THRESHOLD_RST;
  logic [LIMIT_W-1:0]        table_cap  = TABLE_LIMIT_RST;
  logic                      by_signal  = SIGNAL_MODE_RST;
  logic [LIMIT_W-1:0]        lead_count = PARENTS_WANTED_RST;

  // results the block still owes, oldest first
  nte_out_t reports_due [$];
  nte_out_t due_rep;
  int       mismatch_count = 0;

  // idling controls, written only by the stimulus process
  bit send_idle_en  = 1'b1;
  bit recv_idle_en  = 1'b1;
  bit hold_off_want = 1'b0;

  neighbor_table_with_eviction dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // store one neighbor into the shadow table, returns its status
  function automatic nte_status_t store_neighbor(nte_entry_t nb);
    int victim;
    int cap;
    bit found;
    bit better;
    victim = 0;
    found  = 1'b0;
    if (rssi_floor != 0 && $signed(nb.rssi) < $signed(rssi_floor)) return ST_BELOW_THRESHOLD;
    // the last entry with the same id wins
    for (int i = 0; i < nbr_count; i++) begin
      if (nbr_table[i].id == nb.id) begin
        victim = i;
        found  = 1'b1;
      end
    end
    if (found) begin
      nbr_table[victim] = nb;
      return ST_UPDATED;
    end
    cap = (int'(table_cap) < MAX_ENTRIES_DFLT) ? int'(table_cap) : MAX_ENTRIES_DFLT;
    if (nbr_count < cap) begin
      nbr_table[nbr_count] = nb;
      nbr_count++;
      return ST_INSERTED;
    end
    // empty table with a zero limit
    if (nbr_count == 0) return ST_REFUSED;
    // victim search over every valid entry, even above a lowered limit
    for (int i = 1; i < nbr_count; i++) begin
      if (!by_signal) begin
        better = (nbr_table[i].level > nbr_table[victim].level) ||
                 (nbr_table[i].level == nbr_table[victim].level &&
                  $signed(nbr_table[i].rssi) < $signed(nbr_table[victim].rssi));
      end else begin
        better = ($signed(nbr_table[i].rssi) < $signed(nbr_table[victim].rssi)) ||
                 ($signed(nbr_table[i].rssi) == $signed(nbr_table[victim].rssi) &&
                  nbr_table[i].level > nbr_table[victim].level);
      end
      if (better) victim = i;
    end
    if (!by_signal && nb.level > nbr_table[victim].level) return ST_REFUSED;
    if (by_signal && $signed(nb.rssi) < $signed(nbr_table[victim].rssi)) return ST_REFUSED;
    // compact behind the victim and append the newcomer
    for (int i = victim; i + 1 < nbr_count; i++) nbr_table[i] = nbr_table[i + 1];
    nbr_table[nbr_count - 1] = nb;
    return ST_REPLACED;
  endfunction

  // apply one accepted transaction to the shadow table and queue what it owes
  function automatic void table_apply_txn(nte_in_t txn, logic pinned, nte_status_t pin);
    nte_out_t   rep;
    nte_entry_t nb;
    int         want;
    rep      = '0;
    rep.last = 1'b1;
    case (txn.mode)
      MODE_STORE: begin
        nb.id       = txn.neighbor_id;
        nb.sink     = txn.neighbor_sink;
        nb.level    = txn.neighbor_level;
        nb.rssi     = txn.neighbor_rssi;
        rep.status  = store_neighbor(nb);
      end
      MODE_CLEAR: begin
        nbr_count  = 0;
        rep.status = ST_CLEARED;
      end
      MODE_READ: begin
        // a wanted count of zero reads one entry
        want = (lead_count == 0) ? 1 : int'(lead_count);
        if (want > nbr_count) want = nbr_count;
        if (want > READ_CAP) want = READ_CAP;
        if (want == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < want; i++) begin
            rep.status      = ST_ENTRY;
            rep.entry_id    = nbr_table[i].id;
            rep.entry_sink  = nbr_table[i].sink;
            rep.entry_level = nbr_table[i].level;
            rep.entry_rssi  = nbr_table[i].rssi;
            rep.last        = (i + 1 == want);
            reports_due     = {reports_due, rep};
          end
          return;
        end
      end
      default: return;    // unused mode: no result, no change
    endcase
    if (pinned) rep.status = pin;
    reports_due = {reports_due, rep};
  endfunction

  function automatic void flag_mismatch(bit have_due, nte_out_t due, nte_out_t got);
    if (mismatch_count < REPORT_LIMIT) begin
      if (have_due)
        $display("mismatch: expected status=%s id=%h sink=%h level=%0d rssi=%0d last=%b",
                 due.status.name(), due.entry_id, due.entry_sink, due.entry_level,
                 $signed(due.entry_rssi), due.last);
      else
        $display("mismatch: result arrived with nothing due");
      $display("          actual   status=%s id=%h sink=%h level=%0d rssi=%0d last=%b",
               got.status.name(), got.entry_id, got.entry_sink, got.entry_level,
               $signed(got.entry_rssi), got.last);
    end
    mismatch_count++;
  endfunction

  // monitor: predict on input transactions, compare on result transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) table_apply_txn(in_data, offer_pinned, offer_pin_status);
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          flag_mismatch(1'b0, '0, out_data);
        end else begin
          due_rep = reports_due.pop_front();
          if (out_data.status      !== due_rep.status      ||
              out_data.entry_id    !== due_rep.entry_id    ||
              out_data.entry_sink  !== due_rep.entry_sink  ||
              out_data.entry_level !== due_rep.entry_level ||
              out_data.entry_rssi  !== due_rep.entry_rssi  ||
              out_data.last        !== due_rep.last)
            flag_mismatch(1'b1, due_rep, out_data);
        end
      end
    end
  end

  // result side: random stalls, one long hold-off, or always ready
  initial begin : result_ready_drive
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_off_want && !hold_done) begin
        // input keeps offering while the held result blocks acceptance
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (recv_idle_en) begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one transaction and hold it until accepted
  task automatic offer_neighbor_txn(input nte_in_t txn, input logic pinned,
                                    input nte_status_t pin);
    if (send_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid         <= 1'b1;
    in_data          <= txn;
    offer_pinned     <= pinned;
    offer_pin_status <= pin;
    do @(posedge clk); while (!in_ready);
  endtask

  // let the block run dry before touching its registers
  task automatic settle_table();
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_GUARD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_RSSI_THRESHOLD: rssi_floor = val[RSSI_W-1:0];
      CFG_TABLE_LIMIT:    table_cap  = val[LIMIT_W-1:0];
      CFG_SIGNAL_MODE:    by_signal  = val[0];
      CFG_PARENTS_WANTED: lead_count = val[LIMIT_W-1:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic dir_row_t store_row(logic [31:0] id, logic [31:0] sink, logic [31:0] lvl,
                                         logic [31:0] rssi, logic pinned, nte_status_t pin);
    dir_row_t r;
    r                    = '0;
    r.kind               = ROW_TXN;
    r.txn.mode           = MODE_STORE;
    r.txn.neighbor_id    = id[15:0];
    r.txn.neighbor_sink  = sink[15:0];
    r.txn.neighbor_level = lvl[7:0];
    r.txn.neighbor_rssi  = rssi[RSSI_W-1:0];
    r.pinned             = pinned;
    r.pin_status         = pin;
    return r;
  endfunction

  function automatic dir_row_t op_row(nte_mode_t mode, logic pinned, nte_status_t pin);
    dir_row_t r;
    r            = '0;
    r.kind       = ROW_TXN;
    r.txn.mode   = mode;
    r.pinned     = pinned;
    r.pin_status = pin;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    dir_row_t r;
    r         = '0;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val[CFG_W-1:0];
    return r;
  endfunction

  // mostly well-formed stores over a small id pool, with reads, clears and noise
  function automatic nte_in_t random_txn(logic [15:0] id_base, int id_pool);
    nte_in_t     t;
    int          roll;
    logic [31:0] rnd;
    logic [31:0] pick;
    t    = '0;
    roll = $urandom_range(0, 99);
    rnd  = $urandom;
    t.neighbor_sink = rnd[15:0];
    if (roll < 6) begin
      // noise: every field over its whole range, unused mode included
      t.mode           = nte_mode_t'(rnd[17:16]);
      rnd              = $urandom;
      t.neighbor_id    = rnd[15:0];
      t.neighbor_level = rnd[23:16];
      rnd              = $urandom;
      t.neighbor_rssi  = rnd[RSSI_W-1:0];
    end else if (roll < 12) begin
      t.mode = MODE_CLEAR;
    end else if (roll < 27) begin
      t.mode = MODE_READ;
    end else begin
      t.mode        = MODE_STORE;
      pick          = id_base + $urandom_range(0, id_pool);
      t.neighbor_id = pick[15:0];
      // few distinct levels and strengths so ties show up
      roll = $urandom_range(0, 99);
      if (roll < 50)      pick = $urandom_range(0, 3);
      else if (roll < 80) pick = $urandom_range(0, 255);
      else                pick = (roll < 90) ? 0 : 255;
      t.neighbor_level = pick[7:0];
      roll = $urandom_range(0, 99);
      if (roll < 50)      pick = $urandom_range(0, 3) * 4 - 8;
      else if (roll < 80) pick = $urandom_range(0, 600) - 300;
      else                pick = $urandom;
      t.neighbor_rssi = pick[RSSI_W-1:0];
    end
    return t;
  endfunction

  initial begin : stimulus
    dir_row_t    directed_rows [$];
    dir_row_t    row;
    nte_in_t     txn;
    logic [31:0] thr;
    logic [31:0] lim;
    logic [31:0] sig;
    logic [31:0] want;
    logic [31:0] id_base;
    int          issued;
    int          waited;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, starting from reset settings
    directed_rows = {directed_rows, op_row(MODE_READ, 1'b1, ST_EMPTY)};
    directed_rows = {directed_rows, store_row(0, 0, 0, -2048, 1'b1, ST_INSERTED)};
    directed_rows = {directed_rows, store_row(16'hFFFF, 16'hFFFF, 255, 2047, 1'b1, ST_INSERTED)};
    directed_rows = {directed_rows, store_row(0, 16'h1234, 5, 100, 1'b1, ST_UPDATED)};
    directed_rows = {directed_rows, op_row(MODE_READ, 1'b0, ST_ENTRY)};
    directed_rows = {directed_rows, reg_row(CFG_PARENTS_WANTED, 16)};
    directed_rows = {directed_rows, op_row(MODE_READ, 1'b0, ST_ENTRY)};
    // threshold active: one step below is dropped, equal passes
    directed_rows = {directed_rows, reg_row(CFG_RSSI_THRESHOLD, -100)};
    directed_rows = {directed_rows, store_row(5, 1, 3, -101, 1'b1, ST_BELOW_THRESHOLD)};
    directed_rows = {directed_rows, store_row(6, 2, 10, -100, 1'b1, ST_INSERTED)};
    // full table in level mode
    directed_rows = {directed_rows, reg_row(CFG_TABLE_LIMIT, 3)};
    directed_rows = {directed_rows, store_row(7, 3, 20, 50, 1'b1, ST_REPLACED)};
    directed_rows = {directed_rows, store_row(8, 4, 21, 0, 1'b1, ST_REFUSED)};
    directed_rows = {directed_rows, store_row(9, 5, 20, 60, 1'b0, ST_INSERTED)};
    // two entries tie on level and strength, the first one goes
    directed_rows = {directed_rows, store_row(6, 6, 20, 60, 1'b0, ST_INSERTED)};
    directed_rows = {directed_rows, store_row(10, 7, 2, 70, 1'b0, ST_INSERTED)};
    // signal mode, threshold off
    directed_rows = {directed_rows, reg_row(CFG_SIGNAL_MODE, 1)};
    directed_rows = {directed_rows, reg_row(CFG_RSSI_THRESHOLD, 0)};
    directed_rows = {directed_rows, store_row(11, 8, 1, 59, 1'b1, ST_REFUSED)};
    directed_rows = {directed_rows, store_row(12, 9, 9, 60, 1'b0, ST_INSERTED)};
    // limit lowered below the count: eviction still looks at all entries
    directed_rows = {directed_rows, reg_row(CFG_TABLE_LIMIT, 1)};
    directed_rows = {directed_rows, store_row(14, 10, 0, 2047, 1'b1, ST_REPLACED)};
    directed_rows = {directed_rows, op_row(MODE_READ, 1'b0, ST_ENTRY)};
    // zero limit, then empty table with zero limit
    directed_rows = {directed_rows, reg_row(CFG_TABLE_LIMIT, 0)};
    directed_rows = {directed_rows, store_row(15, 11, 0, 2047, 1'b1, ST_REPLACED)};
    directed_rows = {directed_rows, op_row(MODE_CLEAR, 1'b1, ST_CLEARED)};
    directed_rows = {directed_rows, store_row(16, 12, 0, 0, 1'b1, ST_REFUSED)};
    directed_rows = {directed_rows, op_row(MODE_READ, 1'b1, ST_EMPTY)};
    // wanted count of zero reads a single entry
    directed_rows = {directed_rows, reg_row(CFG_TABLE_LIMIT, 16)};
    directed_rows = {directed_rows, reg_row(CFG_PARENTS_WANTED, 0)};
    directed_rows = {directed_rows, store_row(16'h8000, 16'h7FFF, 128, -1, 1'b1, ST_INSERTED)};
    directed_rows = {directed_rows, op_row(MODE_READ, 1'b0, ST_ENTRY)};
    directed_rows = {directed_rows, op_row(MODE_NONE, 1'b0, ST_INSERTED)};

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        settle_table();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        offer_neighbor_txn(row.txn, row.pinned, row.pin_status);
      end
    end

    // random phases, each under its own register settings
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin thr = 0;     lim = 16; sig = 0; want = 16; end
        1: begin thr = -2048; lim = 1;  sig = 1; want = 1;  end
        2: begin thr = $urandom_range(0, 400) - 300; lim = 4; sig = 0; want = 3; end
        3: begin thr = 2047;  lim = 8;  sig = 1; want = 16; end
        4: begin
          thr  = $urandom_range(0, 400) - 300;
          lim  = $urandom_range(1, 16);
          sig  = $urandom_range(0, 1);
          want = $urandom_range(1, 16);
        end
        default: begin thr = 0; lim = 16; sig = 1; want = 16; end
      endcase
      settle_table();
      write_reg(CFG_RSSI_THRESHOLD, thr[CFG_W-1:0]);
      write_reg(CFG_TABLE_LIMIT, lim[CFG_W-1:0]);
      write_reg(CFG_SIGNAL_MODE, sig[CFG_W-1:0]);
      write_reg(CFG_PARENTS_WANTED, want[CFG_W-1:0]);
      id_base = $urandom;
      // long receiver hold-off while the sender keeps going
      if (phase == 2) hold_off_want = 1'b1;
      // last phase runs with no idling on either side
      if (phase == PHASE_COUNT - 1) begin
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
      end
      issued = 0;
      while (issued < PHASE_TXNS) begin
        txn = random_txn(id_base[15:0], int'(lim) + 4);
        offer_neighbor_txn(txn, 1'b0, ST_INSERTED);
        if (txn.mode != MODE_NONE) issued++;
      end
    end

    // drain, with a bound, then a quiet tail for stray results
    in_valid <= 1'b0;
    waited = 0;
    while (reports_due.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_GUARD) @(posedge clk);
    mismatch_count += reports_due.size();

    if (mismatch_count == 0)
      $display("neighbor_table_with_eviction regression: pass");
    else
      $display("neighbor_table_with_eviction regression: fail");
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : run_limit
    #400000;
    $display("neighbor_table_with_eviction regression: fail");
    $finish;
  end

endmodule

// ===== neighbor_table_with_eviction.f =====
+incdir+rtl/core
rtl/core/nte_pkg.sv
rtl/core/nte_entry_ram.sv
rtl/core/neighbor_table_with_eviction.sv
test/tb_top.sv
